// ===== sv/ffba_pkg.sv =====
// Shared types, constants and codes of the first-fit block allocator.
package ffba_pkg;

    localparam int HEAP_BYTES = 65536;
    localparam int GRANULE_BYTES = 16;
    localparam int GRANULES = HEAP_BYTES / GRANULE_BYTES;
    localparam int GRAN_W = $clog2(GRANULES);
    localparam int SIZE_W = GRAN_W;
    localparam int ENTRY_W = SIZE_W + 1;
    localparam int NEED_W = 13;
    localparam int TARGET_W = 12;
    localparam int CMP_W = (GRAN_W + 1 > NEED_W) ? GRAN_W + 1 : NEED_W;
    localparam int PAY_W = (GRAN_W + 5 > 16) ? GRAN_W + 5 : 16;

    localparam logic [GRAN_W-1:0] PROLOGUE_HDR = GRAN_W'(1);
    localparam logic [GRAN_W-1:0] FIRST_FREE_HDR = GRAN_W'(3);
    localparam logic [GRAN_W-1:0] TERM_HDR = GRAN_W'(GRANULES - 1);
    localparam logic [SIZE_W-1:0] PROLOGUE_SIZE = SIZE_W'(2);
    localparam logic [SIZE_W-1:0] FIRST_FREE_SIZE = SIZE_W'(GRANULES - 4);
    localparam logic [SIZE_W-1:0] SPLIT_MIN_GRANULES = SIZE_W'(3);
    localparam logic [16:0] NEED_ROUND = 17'd47;
    localparam logic [15:0] MIN_FREE_ADDR = 16'd32;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE = 1'b1;

    localparam logic [1:0] STATUS_OK = 2'd0;
    localparam logic [1:0] STATUS_NOMEM = 2'd1;
    localparam logic [1:0] STATUS_BADADDR = 2'd2;

    typedef struct packed {
        logic        mode;
        logic [15:0] request_bytes;
        logic [15:0] free_address;
    } ffba_in_t;

    typedef struct packed {
        logic [15:0] payload_address;
        logic [1:0]  status;
    } ffba_out_t;

    typedef struct packed {
        logic              alloc;
        logic [SIZE_W-1:0] size;
    } hdr_entry_t;

    typedef enum logic [2:0] {
        S_INIT_PRO,
        S_INIT_FREE,
        S_INIT_TERM,
        S_IDLE,
        S_WALK,
        S_SPLIT,
        S_DONE
    } ffba_state_t;

endpackage

// ===== sv/ffba_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module ffba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/ffba_ctrl.sv =====
// Sequencer that walks the block headers in the RAM and updates them.
module ffba_ctrl
    import ffba_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  ffba_in_t            in_data,
    output logic                res_valid,
    input  logic                res_ready,
    output ffba_out_t           res_data,
    output logic [GRAN_W-1:0]   ram_rd_addr,
    input  logic [ENTRY_W-1:0]  ram_rd_data,
    output logic                ram_wr_en,
    output logic [GRAN_W-1:0]   ram_wr_addr,
    output logic [ENTRY_W-1:0]  ram_wr_data
);

    ffba_state_t         state_reg, state_next;
    logic                mode_reg;
    logic [NEED_W-1:0]   need_reg;
    logic [TARGET_W-1:0] target_reg;
    logic                bad_reg;
    logic [GRAN_W-1:0]   hdr_reg;
    logic [GRAN_W-1:0]   split_addr_reg;
    hdr_entry_t          split_data_reg;
    ffba_out_t           result_reg;

    logic                accept;
    logic [16:0]         need_sum;
    hdr_entry_t          ent;
    logic [GRAN_W:0]     sum;
    logic                at_end;
    logic                fit;
    logic                hit;
    logic                past;
    logic [SIZE_W-1:0]   extra;
    logic                walk_done;
    logic                walk_write;
    logic                walk_split;
    logic [1:0]          walk_status;
    hdr_entry_t          walk_wr_data;
    logic [PAY_W-1:0]    pay_full;

    assign accept = in_valid && in_ready;
    assign need_sum = {1'b0, in_data.request_bytes} + NEED_ROUND;

    assign ent = hdr_entry_t'(ram_rd_data);
    assign sum = {1'b0, hdr_reg} + {1'b0, ent.size};
    assign at_end = (sum >= (GRAN_W + 1)'(GRANULES));
    assign fit = !ent.alloc && (CMP_W'(ent.size) >= CMP_W'(need_reg));
    assign hit = (CMP_W'(hdr_reg) == CMP_W'(target_reg)) && (hdr_reg != PROLOGUE_HDR);
    assign past = CMP_W'(hdr_reg) > CMP_W'(target_reg);
    assign extra = ent.size - SIZE_W'(need_reg);
    assign pay_full = (PAY_W'(hdr_reg) + PAY_W'(1)) << 4;

    always_comb
    begin
        walk_done = 1'b0;
        walk_write = 1'b0;
        walk_split = 1'b0;
        walk_status = STATUS_OK;
        walk_wr_data = ent;
        if (mode_reg == MODE_ALLOC)
        begin
            priority if (ent.size == '0)
            begin
                walk_done = 1'b1;
                walk_status = STATUS_NOMEM;
            end
            else if (fit)
            begin
                walk_done = 1'b1;
                walk_write = 1'b1;
                walk_split = extra > SPLIT_MIN_GRANULES;
                walk_wr_data.alloc = 1'b1;
                if (walk_split)
                begin
                    walk_wr_data.size = SIZE_W'(need_reg);
                end
            end
            else if (at_end)
            begin
                walk_done = 1'b1;
                walk_status = STATUS_NOMEM;
            end
            else
            begin
                walk_done = 1'b0;
            end
        end
        else
        begin
            priority if (bad_reg || ent.size == '0 || past)
            begin
                walk_done = 1'b1;
                walk_status = STATUS_BADADDR;
            end
            else if (hit)
            begin
                walk_done = 1'b1;
                walk_write = 1'b1;
                walk_wr_data.alloc = 1'b0;
            end
            else if (at_end)
            begin
                walk_done = 1'b1;
                walk_status = STATUS_BADADDR;
            end
            else
            begin
                walk_done = 1'b0;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_INIT_PRO:  state_next = S_INIT_FREE;
            S_INIT_FREE: state_next = S_INIT_TERM;
            S_INIT_TERM: state_next = S_IDLE;
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (walk_done)
                begin
                    state_next = walk_split ? S_SPLIT : S_DONE;
                end
            end
            S_SPLIT:     state_next = S_DONE;
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:     state_next = S_INIT_PRO;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        res_valid = 1'b0;
        ram_rd_addr = PROLOGUE_HDR;
        ram_wr_en = 1'b0;
        ram_wr_addr = hdr_reg;
        ram_wr_data = ENTRY_W'(walk_wr_data);
        unique case (state_reg)
            S_INIT_PRO:
            begin
                ram_wr_en = 1'b1;
                ram_wr_addr = PROLOGUE_HDR;
                ram_wr_data = {1'b1, PROLOGUE_SIZE};
            end
            S_INIT_FREE:
            begin
                ram_wr_en = 1'b1;
                ram_wr_addr = FIRST_FREE_HDR;
                ram_wr_data = {1'b0, FIRST_FREE_SIZE};
            end
            S_INIT_TERM:
            begin
                ram_wr_en = 1'b1;
                ram_wr_addr = TERM_HDR;
                ram_wr_data = {1'b1, SIZE_W'(0)};
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
            end
            S_WALK:
            begin
                ram_rd_addr = sum[GRAN_W-1:0];
                ram_wr_en = walk_write;
            end
            S_SPLIT:
            begin
                ram_wr_en = 1'b1;
                ram_wr_addr = split_addr_reg;
                ram_wr_data = ENTRY_W'(split_data_reg);
            end
            S_DONE:
            begin
                res_valid = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT_PRO;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= in_data.mode;
            need_reg <= need_sum[16:4];
            target_reg <= in_data.free_address[15:4] - TARGET_W'(1);
            bad_reg <= (in_data.free_address[3:0] != 4'd0)
                       || (in_data.free_address < MIN_FREE_ADDR);
            hdr_reg <= PROLOGUE_HDR;
        end
        else if (state_reg == S_WALK)
        begin
            if (walk_done)
            begin
                result_reg.status <= walk_status;
                result_reg.payload_address <=
                    (mode_reg == MODE_ALLOC && walk_status == STATUS_OK) ? pay_full[15:0] : '0;
                split_addr_reg <= hdr_reg + GRAN_W'(need_reg);
                split_data_reg <= '{alloc: 1'b0, size: extra};
            end
            else
            begin
                hdr_reg <= sum[GRAN_W-1:0];
            end
        end
    end

    assign res_data = result_reg;

endmodule

// ===== sv/ffba_out_reg.sv =====
// Output register that holds a finished result until its transfer.
module ffba_out_reg
    import ffba_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      res_valid,
    output logic      res_ready,
    input  ffba_out_t res_data,
    output logic      out_valid,
    input  logic      out_ready,
    output ffba_out_t out_data
);

    logic      out_valid_reg, out_valid_next;
    ffba_out_t out_data_reg;

    assign res_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_ready)
        begin
            out_valid_next = res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_data_reg <= res_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data = out_data_reg;

endmodule

// ===== sv/first_fit_block_allocator_unit.sv =====
// First-fit block allocator over an implicit list of block headers held in one RAM.
// Each request is accepted while the block is idle and then walks the block headers on the list,
// reading one header per cycle from the header RAM; an allocation that splits its block
// writes the second header in a further state, and the result then passes to the output
// register. An allocation visits at most about half the granule count of headers; a
// free stops once the walk reaches or passes the named block. After reset the block
// writes the prologue, first free block and terminator headers in turn and takes no
// request until they are written. A finished result waits in the output register while
// the next request is accepted.
module first_fit_block_allocator_unit
    import ffba_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  ffba_in_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output ffba_out_t out_data
);

    logic               res_valid;
    logic               res_ready;
    ffba_out_t          res_data;
    logic [GRAN_W-1:0]  ram_rd_addr;
    logic [ENTRY_W-1:0] ram_rd_data;
    logic               ram_wr_en;
    logic [GRAN_W-1:0]  ram_wr_addr;
    logic [ENTRY_W-1:0] ram_wr_data;

    ffba_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res_data    (res_data),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data)
    );

    ffba_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (GRANULES)
    ) u_hdr_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    ffba_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ===== sv/ffba_checker.sv =====
// Port-level checker for the allocator and its bind to the top level.
module ffba_checker
    import ffba_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input ffba_out_t out_data
);

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.status == STATUS_OK || out_data.status == STATUS_NOMEM
                       || out_data.status == STATUS_BADADDR))
        else $error("Result carries an undefined status code.");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != STATUS_OK |-> out_data.payload_address == 16'd0)
        else $error("Failed request reports a nonzero payload address.");

    a_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.payload_address[3:0] == 4'd0)
        else $error("Payload address is not granule aligned.");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("Stalled result changed before its transfer.");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("A second request was taken while one was in progress.");

endmodule

bind first_fit_block_allocator_unit ffba_checker u_ffba_checker (.*);

// ===== test/ffba_checker.sv =====
`timescale 1ns / 100ps
// Checker for the allocator: shadows the header list, predicts every result and compares it.
module ffba_scoreboard
    import ffba_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_ready,
    input  ffba_in_t  in_data,
    input  logic      out_valid,
    input  logic      out_ready,
    input  ffba_out_t out_data,
    output int        mismatches,
    output int        pending,
    output int        grants,
    output int        nomem_seen,
    output int        badaddr_seen
);

    hdr_entry_t heap_hdr [GRANULES];
    ffba_out_t  awaited_responses [$];

    function automatic int next_block(int hdr);
        int s;
        if (hdr >= GRANULES)
            return GRANULES;
        s = int'(heap_hdr[hdr].size);
        if (s == 0 || s >= GRANULES - hdr)
            return GRANULES;
        return hdr + s;
    endfunction

    function automatic bit is_block(int hdr);
        if (hdr >= GRANULES)
            return 1'b0;
        return heap_hdr[hdr].size != '0;
    endfunction

    function automatic ffba_out_t heap_response(ffba_in_t req);
        ffba_out_t res;
        int        need;
        int        hdr;
        int        extra;
        int        target;
        res = '0;
        res.status = STATUS_OK;
        if (req.mode == MODE_ALLOC)
        begin
            need = (int'(req.request_bytes) + int'(NEED_ROUND)) / GRANULE_BYTES;
            for (hdr = int'(PROLOGUE_HDR); is_block(hdr); hdr = next_block(hdr))
            begin
                if (!heap_hdr[hdr].alloc && int'(heap_hdr[hdr].size) >= need)
                begin
                    extra = int'(heap_hdr[hdr].size) - need;
                    if (extra > int'(SPLIT_MIN_GRANULES))
                    begin
                        heap_hdr[hdr].size = SIZE_W'(need);
                        heap_hdr[hdr + need].size = SIZE_W'(extra);
                        heap_hdr[hdr + need].alloc = 1'b0;
                    end
                    heap_hdr[hdr].alloc = 1'b1;
                    res.payload_address = 16'((hdr + 1) * GRANULE_BYTES);
                    return res;
                end
            end
            res.status = STATUS_NOMEM;
            return res;
        end
        if ((int'(req.free_address) % GRANULE_BYTES) != 0 || req.free_address < MIN_FREE_ADDR)
        begin
            res.status = STATUS_BADADDR;
            return res;
        end
        target = int'(req.free_address) / GRANULE_BYTES - 1;
        for (hdr = next_block(int'(PROLOGUE_HDR)); is_block(hdr) && hdr <= target;
             hdr = next_block(hdr))
        begin
            if (hdr == target)
            begin
                heap_hdr[hdr].alloc = 1'b0;
                return res;
            end
        end
        res.status = STATUS_BADADDR;
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        ffba_out_t want;
        if (!rst_n)
        begin
            for (int g = 0; g < GRANULES; g++)
                heap_hdr[g] = '0;
            heap_hdr[PROLOGUE_HDR].size = PROLOGUE_SIZE;
            heap_hdr[PROLOGUE_HDR].alloc = 1'b1;
            heap_hdr[FIRST_FREE_HDR].size = FIRST_FREE_SIZE;
            heap_hdr[FIRST_FREE_HDR].alloc = 1'b0;
            heap_hdr[TERM_HDR].size = '0;
            heap_hdr[TERM_HDR].alloc = 1'b1;
            awaited_responses.delete();
            mismatches = 0;
            grants = 0;
            nomem_seen = 0;
            badaddr_seen = 0;
            pending <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (awaited_responses.size() == 0)
                    report_mismatch($sformatf("unexpected result address %0d status %0d",
                                              out_data.payload_address, out_data.status));
                else
                begin
                    want = awaited_responses.pop_front();
                    if (out_data.payload_address !== want.payload_address)
                        report_mismatch($sformatf("payload_address %0d, expected %0d",
                                                  out_data.payload_address,
                                                  want.payload_address));
                    if (out_data.status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  out_data.status, want.status));
                end
                if (out_data.status == STATUS_NOMEM)
                    nomem_seen++;
                else if (out_data.status == STATUS_BADADDR)
                    badaddr_seen++;
                else if (out_data.payload_address != '0)
                    grants++;
            end
            if (in_valid && in_ready)
                awaited_responses.push_back(heap_response(in_data));
            pending <= awaited_responses.size();
        end
    end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// Top of the allocator testbench: clock, reset, request stimulus, result pacing and verdict.
module testbench;
    import ffba_pkg::*;

    localparam int RANDOM_ITEMS = 270;
    localparam int TAIL_CYCLES = 2100;
    localparam int CYCLE_LIMIT = 3000000;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    ffba_in_t  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    ffba_out_t out_data;

    int send_idle = 26;
    int recv_idle = 47;
    int cycles = 0;
    int alloc_sent = 0;
    int free_sent = 0;
    int mismatches;
    int pending;
    int grants;
    int nomem_seen;
    int badaddr_seen;

    logic [15:0] live_payloads [$];

    always #2 clk = ~clk;

    first_fit_block_allocator_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    ffba_scoreboard scoreboard (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data),
        .mismatches   (mismatches),
        .pending      (pending),
        .grants       (grants),
        .nomem_seen   (nomem_seen),
        .badaddr_seen (badaddr_seen)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge clk)
        out_ready <= rst_n && ($urandom_range(0, 99) >= recv_idle);

    // Granted addresses are remembered so that frees mostly name live blocks.
    task automatic next_cycle();
        @(posedge clk);
        if (out_valid && out_ready && out_data.status == STATUS_OK
            && out_data.payload_address != '0)
            live_payloads.push_back(out_data.payload_address);
    endtask

    task automatic send_request(input ffba_in_t item);
        while ($urandom_range(0, 99) < send_idle)
        begin
            in_valid <= 1'b0;
            next_cycle();
        end
        in_valid <= 1'b1;
        in_data <= item;
        if (item.mode == MODE_ALLOC)
            alloc_sent++;
        else
            free_sent++;
        next_cycle();
        while (!in_ready)
            next_cycle();
    endtask

    function automatic ffba_in_t alloc_of(input logic [15:0] bytes);
        ffba_in_t item;
        item.mode = MODE_ALLOC;
        item.request_bytes = bytes;
        item.free_address = 16'($urandom);
        return item;
    endfunction

    function automatic ffba_in_t free_of(input logic [15:0] addr);
        ffba_in_t item;
        item.mode = MODE_FREE;
        item.request_bytes = 16'($urandom);
        item.free_address = addr;
        return item;
    endfunction

    function automatic ffba_in_t random_request();
        ffba_in_t item;
        int       roll;
        int       pick;
        item = alloc_of(16'($urandom));
        roll = $urandom_range(0, 99);
        if (roll < 40)
            item.request_bytes = 16'($urandom_range(0, 400));
        else if (roll < 48)
            item.request_bytes = 16'($urandom_range(0, 48));
        else if (roll < 56)
            item.request_bytes = 16'($urandom_range(1000, 16000));
        else if (roll >= 60)
        begin
            item.mode = MODE_FREE;
            if (roll < 88 && live_payloads.size() > 0)
            begin
                pick = $urandom_range(0, live_payloads.size() - 1);
                item.free_address = live_payloads[pick];
                if ($urandom_range(0, 9) != 0)
                    live_payloads.delete(pick);
            end
            else if (roll < 92 && live_payloads.size() > 0)
            begin
                pick = $urandom_range(0, live_payloads.size() - 1);
                item.free_address = live_payloads[pick] + 16'($urandom_range(1, 40));
            end
            else if (roll < 96)
                item.free_address = 16'($urandom_range(0, GRANULES - 1) * GRANULE_BYTES);
        end
        return item;
    endfunction

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        next_cycle();

        // One byte too many for the heap, then the whole heap taken exactly.
        send_request(alloc_of(16'd65441));
        send_request(alloc_of(16'd65440));
        send_request(alloc_of(16'd0));
        send_request(free_of(16'd64));
        send_request(alloc_of(16'd0));
        send_request(alloc_of(16'd1));
        send_request(alloc_of(16'd17));
        send_request(alloc_of(16'h5555));
        send_request(alloc_of(16'hFFFF));
        send_request(alloc_of(16'hAAAA));
        // Free, double free, prologue and addresses that name no block.
        send_request(free_of(16'd64));
        send_request(free_of(16'd64));
        send_request(free_of(16'd32));
        send_request(free_of(16'd16));
        send_request(free_of(16'd0));
        send_request(free_of(16'd65));
        send_request(free_of(16'd80));
        send_request(free_of(16'hFFFF));
        send_request(free_of(16'hFFF0));
        // Reuse of freed blocks, with and without a remainder too small to split.
        send_request(alloc_of(16'd0));
        send_request(free_of(16'd144));
        send_request(alloc_of(16'd0));
        send_request(free_of(16'd144));

        for (int phase = 0; phase < 3; phase++)
        begin
            if (phase == 1)
            begin
                send_idle = 47;
                recv_idle <= 26;
            end
            else if (phase == 2)
            begin
                send_idle = 0;
                recv_idle <= 0;
            end
            for (int n = 0; n < RANDOM_ITEMS / 3; n++)
                send_request(random_request());
        end

        in_valid <= 1'b0;
        next_cycle();
        while (pending != 0)
            next_cycle();
        repeat (TAIL_CYCLES) next_cycle();

        $display("Sent %0d allocate and %0d free requests over three pacing phases.",
                 alloc_sent, free_sent);
        $display("Seen %0d grants, %0d out of memory, %0d bad free addresses.",
                 grants, nomem_seen, badaddr_seen);
        if (mismatches == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
